>>> rtl/core/rce_pkg.sv
// shared constants and types for the roberts cross edge block
`default_nettype none

package rce_pkg;

    // frame limits
    localparam int MAX_LINE = 2048;
    localparam int MAX_ROWS = 4096;

    // position counter widths
    localparam int COL_W = $clog2(MAX_LINE);
    localparam int ROW_W = $clog2(MAX_ROWS);

    // register widths
    localparam int LINE_WIDTH_W   = 12;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int GAIN_W         = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 2'd2;

    // register reset values
    localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 12'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [GAIN_W-1:0]         GAIN_RST         = 4'd2;

    // pixel layout
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    // stream widths
    localparam int IN_TDATA_W  = PIX_W;
    localparam int OUT_FIELD_W = PIX_W + COL_W + ROW_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // one pixel, blue in the low byte
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    // pixel waiting for its line buffer read
    typedef struct packed {
        t_pixel           pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             emit;
    } t_stage;

endpackage

`default_nettype wire

>>> rtl/core/rce_ram.sv
// generic simple dual port ram with registered read, read-first on collision
`default_nettype none

module rce_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/roberts_cross_edge_rgb.sv
// Roberts cross edge detector for an RGB pixel stream in raster order.
// Takes one pixel per clock; the result for the pixel that completes a 2x2
// window is registered in the gradient stage and then in the output register;
// pixels in row 0 or column 0 give no result. The previous row sits in one
// line buffer RAM that is read and written at the pixel's column in the
// cycle the pixel is taken, the read returning the old entry; its registered
// read output feeds the gradient stage with the pixel, so the sustained rate
// is one pixel per clock and is set by that single RAM access per pixel. A
// stall on the output holds the input only once the output register and the
// gradient stage are both full. No clearing pass is needed after reset.
`default_nettype none

module roberts_cross_edge_rgb
    import rce_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration writes
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data,
    // pixel input
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]     s_axis_tdata,  // in_blue, in_green, in_red
    // edge output
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic      [OUT_TDATA_W-1:0]    m_axis_tdata   // out_blue, out_green, out_red,
                                                          // out_column, out_row, zero pad
);

    // configuration registers
    logic [LINE_WIDTH_W-1:0]   r_line_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;
    logic [GAIN_W-1:0]         r_gain;

    // position and window state
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_pixel           r_left;
    t_pixel           r_upper_left;

    // gradient stage and output register
    logic             r_s1_valid;
    t_stage           r_s1, n_s1;
    logic             r_out_valid;
    t_pixel           r_out_pix, n_out_pix;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;

    logic                      in_req;
    logic                      s1_fire;
    logic                      s1_load_out;
    logic [LINE_WIDTH_W-1:0]   eff_width;
    logic [FRAME_HEIGHT_W-1:0] eff_height;
    logic [LINE_WIDTH_W-1:0]   col_ext, col_inc;
    logic [FRAME_HEIGHT_W-1:0] row_ext, row_inc;
    t_pixel                    in_pix;
    t_pixel                    above;

    // per channel gradient, scaled and cut to a byte
    function automatic logic [CH_W-1:0] grad(
        input logic [CH_W-1:0]   cur,
        input logic [CH_W-1:0]   ul,
        input logic [CH_W-1:0]   up,
        input logic [CH_W-1:0]   lf,
        input logic [GAIN_W-1:0] g
    );
        logic [CH_W-1:0]        d0;
        logic [CH_W-1:0]        d1;
        logic [CH_W:0]          sum;
        logic [CH_W+GAIN_W:0]   prod;
        d0   = (cur > ul) ? (cur - ul) : (ul - cur);
        d1   = (up > lf) ? (up - lf) : (lf - up);
        sum  = {1'b0, d0} + {1'b0, d1};
        prod = sum * g;
        return prod[CH_W-1:0];
    endfunction

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_gain         <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LINE_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_GAIN:         r_gain         <= i_cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamp frame size to the supported range
    always_comb begin
        if (r_line_width < LINE_WIDTH_W'(2)) begin
            eff_width = LINE_WIDTH_W'(2);
        end else if (r_line_width > LINE_WIDTH_W'(MAX_LINE)) begin
            eff_width = LINE_WIDTH_W'(MAX_LINE);
        end else begin
            eff_width = r_line_width;
        end
        if (r_frame_height < FRAME_HEIGHT_W'(2)) begin
            eff_height = FRAME_HEIGHT_W'(2);
        end else if (r_frame_height > FRAME_HEIGHT_W'(MAX_ROWS)) begin
            eff_height = FRAME_HEIGHT_W'(MAX_ROWS);
        end else begin
            eff_height = r_frame_height;
        end
    end

    // handshake
    assign s1_load_out   = r_s1_valid && r_s1.emit;
    assign s1_fire       = r_s1_valid && (!r_s1.emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign in_pix        = t_pixel'(s_axis_tdata);

    // window position and next position
    always_comb begin
        col_ext = LINE_WIDTH_W'(r_col);
        row_ext = FRAME_HEIGHT_W'(r_row);
        col_inc = col_ext + LINE_WIDTH_W'(1);
        row_inc = row_ext + FRAME_HEIGHT_W'(1);

        n_s1.pix  = in_pix;
        n_s1.col  = r_col - COL_W'(1);
        n_s1.row  = r_row - ROW_W'(1);
        n_s1.emit = (r_col != '0) && (r_row != '0)
                 && (col_ext < eff_width) && (row_ext < eff_height);

        if (col_inc >= eff_width) begin
            n_col = '0;
            n_row = (row_inc >= eff_height) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = r_row;
        end
    end

    // previous row buffer, read and written at the current column
    rce_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (in_req),
        .i_waddr (r_col),
        .i_wdata (PIX_W'(in_pix)),
        .i_re    (in_req),
        .i_raddr (r_col),
        .o_rdata (above)
    );

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_req) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // gradient stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_req) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_req) begin
            r_s1 <= n_s1;
        end
    end

    // left and upper-left pixels advance as each pixel leaves the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_upper_left <= '0;
        end else if (s1_fire) begin
            r_left       <= r_s1.pix;
            r_upper_left <= above;
        end
    end

    // gradient per channel
    always_comb begin
        n_out_pix.blue  = grad(r_s1.pix.blue,  r_upper_left.blue,  above.blue,
                               r_left.blue,  r_gain);
        n_out_pix.green = grad(r_s1.pix.green, r_upper_left.green, above.green,
                               r_left.green, r_gain);
        n_out_pix.red   = grad(r_s1.pix.red,   r_upper_left.red,   above.red,
                               r_left.red,   r_gain);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && s1_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_load_out) begin
            r_out_pix <= n_out_pix;
            r_out_col <= r_s1.col;
            r_out_row <= r_s1.row;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_row, r_out_col, r_out_pix};

endmodule

`default_nettype wire

>>> rtl/core/rce_checker.sv
// port level checks for the roberts cross edge block and their binding
`default_nettype none

module rce_checker
    import rce_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic in_req;
    logic cfg_seen;

    assign in_req   = s_axis_tvalid && s_axis_tready;
    assign cfg_seen = i_cfg_we || (i_cfg_idx != '0) || (i_cfg_data != '0) ||
                      (s_axis_tdata != '0) || 1'b1;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n || !cfg_seen)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a new result must be preceded by an accepted request that completes it
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(in_req, 2))
        else $error("result without a matching request");

    // input is held back only while the output is full and stalled
    a_in_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with output free");

    // window column never reaches the last buffer column and pad stays zero
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[PIX_W+COL_W-1:PIX_W] != {COL_W{1'b1}}) &&
                          (m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W] == '0))
        else $error("result column or pad out of range");

endmodule

bind roberts_cross_edge_rgb rce_checker u_rce_checker (.*);

`default_nettype wire
